FILE: sv/sud_pkg.sv
// ---------------------------------------------------------------------------
// sud_pkg: shared types and constants for the 16-bit divider
// Command codes, per-stage control and data records, pipeline depth.
// ---------------------------------------------------------------------------
package sud_pkg;

  localparam int DW = 16;
  localparam int LATENCY = DW + 2;

  typedef enum logic [1:0] {
    CMD_SQUO = 2'd0,
    CMD_SREM = 2'd1,
    CMD_UREM = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic neg_res;
    logic dbz;
  } ctl_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] nq;
    logic [DW-1:0] dvs;
  } item_t;

endpackage

FILE: sv/signed_unsigned_divider_16.sv
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// The depth is one input register, one cell per quotient bit (16) and one output register.
// Reset (rst_n low, synchronous) drops every item in flight; no result strobes after it.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// signed_unsigned_divider_16: pipelined 16-bit restoring divider
// Signed quotient, signed remainder or unsigned remainder (zero for CMD_NONE)
// through a chain of one-bit division cells, with a divide-by-zero flag.
// ---------------------------------------------------------------------------
module signed_unsigned_divider_16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_dividend,
  input  logic [15:0] in_divisor,
  output logic        out_valid,
  output logic [15:0] out_result,
  output logic        out_div_by_zero
);

  localparam int W = sud_pkg::DW;

  sud_pkg::ctl_t  ctl_s [W+1];
  sud_pkg::item_t itm_s [W+1];

  sud_pkg::ctl_t  pre_ctl_r, pre_ctl_nxt;
  sud_pkg::item_t pre_itm_r, pre_itm_nxt;
  sud_pkg::cmd_t  cmd;
  logic           neg_a, neg_b, signed_op;

  logic           out_valid_r;
  logic [W-1:0]   out_result_r, out_result_nxt;
  logic           out_dbz_r;
  logic [W-1:0]   mag;

  assign busy = 1'b0;

  // input stage: magnitudes and sign of the result
  always_comb begin
    cmd       = sud_pkg::cmd_t'(in_command);
    neg_a     = in_dividend[W-1];
    neg_b     = in_divisor[W-1];
    signed_op = (cmd == sud_pkg::CMD_SQUO) || (cmd == sud_pkg::CMD_SREM);
    pre_ctl_nxt.valid   = start;
    pre_ctl_nxt.cmd     = cmd;
    pre_ctl_nxt.dbz     = (in_divisor == '0);
    pre_ctl_nxt.neg_res = (cmd == sud_pkg::CMD_SQUO) ? (neg_a ^ neg_b) : neg_a;
    pre_itm_nxt.rem = '0;
    pre_itm_nxt.nq  = (signed_op && neg_a) ? (W'(0) - in_dividend) : in_dividend;
    pre_itm_nxt.dvs = (signed_op && neg_b) ? (W'(0) - in_divisor) : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r <= '0;
    end else begin
      pre_ctl_r <= pre_ctl_nxt;
    end
    pre_itm_r <= pre_itm_nxt;
  end

  assign ctl_s[0] = pre_ctl_r;
  assign itm_s[0] = pre_itm_r;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sud_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .itm_i (itm_s[i]),
      .ctl_o (ctl_s[i+1]),
      .itm_o (itm_s[i+1])
    );
  end

  // output stage: pick quotient or remainder and fix its sign
  always_comb begin
    mag = itm_s[W].rem;
    unique case (ctl_s[W].cmd)
      sud_pkg::CMD_SQUO: mag = itm_s[W].nq;
      sud_pkg::CMD_SREM,
      sud_pkg::CMD_UREM: mag = itm_s[W].rem;
      default:           mag = '0;
    endcase
    if (ctl_s[W].dbz || ctl_s[W].cmd == sud_pkg::CMD_NONE) begin
      out_result_nxt = '0;
    end else if (ctl_s[W].cmd != sud_pkg::CMD_UREM && ctl_s[W].neg_res) begin
      out_result_nxt = W'(0) - mag;
    end else begin
      out_result_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_s[W].valid;
    end
    out_result_r <= out_result_nxt;
    out_dbz_r    <= ctl_s[W].dbz;
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dbz_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(sud_pkg::LATENCY) out_valid)
    else $error("item did not come out after the pipeline depth");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_result == '0)
    else $error("divide by zero gave a nonzero result");

  a_dbz_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[W].valid |=> out_div_by_zero == $past(ctl_s[W].dbz))
    else $error("divide-by-zero flag lost in output stage");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl_s[W].valid))
    else $error("result strobe without an item in the last cell");
`endif

endmodule

FILE: sv/sud_cell.sv
// ---------------------------------------------------------------------------
// sud_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in, then registers the item.
// ---------------------------------------------------------------------------
module sud_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  sud_pkg::ctl_t  ctl_i,
  input  sud_pkg::item_t itm_i,
  output sud_pkg::ctl_t  ctl_o,
  output sud_pkg::item_t itm_o
);

  sud_pkg::ctl_t  ctl_r;
  sud_pkg::item_t itm_r;
  sud_pkg::item_t itm_nxt;
  logic [sud_pkg::DW:0] shifted;
  logic [sud_pkg::DW:0] diff;
  logic                 qbit;

  always_comb begin
    shifted = {itm_i.rem, itm_i.nq[sud_pkg::DW-1]};
    diff    = shifted - {1'b0, itm_i.dvs};
    qbit    = shifted[sud_pkg::DW] | ~diff[sud_pkg::DW];
    itm_nxt.dvs = itm_i.dvs;
    itm_nxt.nq  = {itm_i.nq[sud_pkg::DW-2:0], qbit};
    itm_nxt.rem = qbit ? diff[sud_pkg::DW-1:0] : shifted[sud_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    itm_r <= itm_nxt;
  end

  assign ctl_o = ctl_r;
  assign itm_o = itm_r;

endmodule

FILE: verif/tb_signed_unsigned_divider_16.sv
// ---------------------------------------------------------------------------
// tb_signed_unsigned_divider_16: self-checking bench for the 16-bit divider
// Drives directed corner items and then random items through the command
// handshake with random gaps. A scoreboard predicts each quotient or
// remainder and the divide-by-zero flag, and checks every strobed result
// in order.
// ---------------------------------------------------------------------------
module tb_signed_unsigned_divider_16;

  localparam int NUM_RANDOM = 900;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    sud_pkg::cmd_t cmd;
    logic [15:0]   dividend;
    logic [15:0]   divisor;
    logic [15:0]   value;
    logic          dbz;
  } div_expect_t;

  class div_scoreboard;
    div_expect_t quotient_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // unsigned restoring division, one quotient bit per step
    function void restore_divide(input logic [15:0] n, input logic [15:0] d,
                                 output logic [15:0] q, output logic [15:0] r);
      logic [16:0] part;
      part = '0;
      q = '0;
      for (int i = 15; i >= 0; i--) begin
        part = {part[15:0], n[i]};
        if (part >= {1'b0, d}) begin
          part = part - {1'b0, d};
          q[i] = 1'b1;
        end
      end
      r = part[15:0];
    endfunction

    function div_expect_t predict(input sud_pkg::cmd_t cmd, input logic [15:0] a,
                                  input logic [15:0] b);
      div_expect_t e;
      logic [15:0] q, r, mag_a, mag_b;
      e.cmd = cmd;
      e.dividend = a;
      e.divisor = b;
      e.value = '0;
      e.dbz = (b == 16'd0);
      mag_a = a[15] ? ~a + 16'd1 : a;
      mag_b = b[15] ? ~b + 16'd1 : b;
      if (!e.dbz) begin
        case (cmd)
          sud_pkg::CMD_SQUO: begin
            restore_divide(mag_a, mag_b, q, r);
            e.value = (a[15] ^ b[15]) ? ~q + 16'd1 : q;
          end
          sud_pkg::CMD_SREM: begin
            restore_divide(mag_a, mag_b, q, r);
            e.value = a[15] ? ~r + 16'd1 : r;
          end
          sud_pkg::CMD_UREM: begin
            restore_divide(a, b, q, r);
            e.value = r;
          end
          default: begin
            e.value = '0;
          end
        endcase
      end
      return e;
    endfunction

    function void note_item(input sud_pkg::cmd_t cmd, input logic [15:0] a,
                            input logic [15:0] b);
      quotient_q.push_back(predict(cmd, a, b));
    endfunction

    task check_result(input logic [15:0] value, input logic dbz);
      div_expect_t e;
      if (quotient_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no item pending", value));
      end else begin
        e = quotient_q.pop_front();
        if (value !== e.value)
          report_mismatch($sformatf("%s %h / %h: result %h, expected %h",
                                    e.cmd.name(), e.dividend, e.divisor, value, e.value));
        if (dbz !== e.dbz)
          report_mismatch($sformatf("%s %h / %h: div_by_zero %b, expected %b",
                                    e.cmd.name(), e.dividend, e.divisor, dbz, e.dbz));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [15:0] in_dividend = '0;
  logic [15:0] in_divisor = '0;
  logic        out_valid;
  logic [15:0] out_result;
  logic        out_div_by_zero;
  int          idle_cycles = 0;

  div_scoreboard sb = new();

  signed_unsigned_divider_16 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_dividend     (in_dividend),
    .in_divisor      (in_divisor),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .out_div_by_zero (out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accepted items and strobed results, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_item(sud_pkg::cmd_t'(in_command), in_dividend, in_divisor);
    if (rst_n && out_valid)
      sb.check_result(out_result, out_div_by_zero);
    if (rst_n && ((start && !busy) || out_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("[signed_unsigned_divider_16] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h7FFF;
          3: return 16'h8000;
          4: return 16'hFFFF;
          default: return 16'hFFFE;
        endcase
      end
      1, 2: return 16'($urandom_range(0, 15));
      3: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  // called at a clock edge; returns at the edge that accepts the item
  task automatic send_item(input sud_pkg::cmd_t cmd, input logic [15:0] a,
                           input logic [15:0] b, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_dividend <= a;
    in_divisor <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.quotient_q.size() != 0);
  endtask

  initial begin
    bit            no_idle;
    sud_pkg::cmd_t cmd;
    logic [15:0]   a, b;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner items
    send_item(sud_pkg::CMD_SQUO, 16'h8000, 16'hFFFF, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'h7FFF, 16'h0001, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'h8000, 16'h0001, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'hFFF9, 16'h0002, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'h0007, 16'hFFFE, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'h0064, 16'h0007, pick_gap());
    send_item(sud_pkg::CMD_SQUO, 16'h1234, 16'h0000, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'h8000, 16'hFFFF, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'hFFF9, 16'h0002, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'h0007, 16'hFFFE, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'h8000, 16'h7FFF, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'h0000, 16'h0005, pick_gap());
    send_item(sud_pkg::CMD_SREM, 16'hFFFF, 16'h0000, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'hFFFF, 16'h0001, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'hFFFF, 16'hFFFF, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'hFFFE, 16'hFFFF, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'h8000, 16'h7FFF, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'h0000, 16'hFFFF, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'hABCD, 16'h0010, pick_gap());
    send_item(sud_pkg::CMD_UREM, 16'h1234, 16'h0000, pick_gap());
    send_item(sud_pkg::CMD_NONE, 16'h1234, 16'h5678, pick_gap());
    send_item(sud_pkg::CMD_NONE, 16'h1234, 16'h0000, pick_gap());
    drain_results();

    // random items, in stretches with and without gaps
    no_idle = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 199) == 0) drain_results();
      cmd = ($urandom_range(0, 19) == 0) ? sud_pkg::CMD_NONE
                                         : sud_pkg::cmd_t'($urandom_range(0, 2));
      a = pick_operand();
      b = ($urandom_range(0, 24) == 0) ? 16'h0000 : pick_operand();
      send_item(cmd, a, b, no_idle ? 0 : pick_gap());
    end

    drain_results();
    repeat (sud_pkg::LATENCY + 4) @(posedge clk);
    if (sb.errors == 0)
      $display("[signed_unsigned_divider_16] OK");
    else
      $display("[signed_unsigned_divider_16] ERROR");
    $finish;
  end

endmodule
